>>> hdl/http_get_request_parser_core_assert.svh
// Assertion macros for the HTTP GET request parser core.
// Included by the top level; no other dependencies.
`ifndef HTTP_GET_REQUEST_PARSER_CORE_ASSERT_SVH
`define HTTP_GET_REQUEST_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HGRP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HGRP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/hgrp_pkg.sv
// Package for the HTTP GET request parser core: phase and status codes,
// match-text lookup functions and the default count width. No dependencies.
`default_nettype none

package hgrp_pkg;

  localparam int unsigned HGRP_COUNT_BITS = 16;

  typedef enum logic [3:0] {
    PH_METHOD  = 4'd0,
    PH_SKIP1   = 4'd1,
    PH_PATH    = 4'd2,
    PH_SKIP2   = 4'd3,
    PH_PROTO   = 4'd4,
    PH_DIGIT   = 4'd5,
    PH_HEADERS = 4'd6
  } phase_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_MALFORMED = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } status_e;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;

  // "GET "
  function automatic logic [7:0] method_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  // "HTTP/1."
  function automatic logic [7:0] proto_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2F;
      3'd5:    c = 8'h31;
      3'd6:    c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/http_get_request_parser_core.sv
// HTTP/1.x GET request line parser, one byte per transaction.
// Depends on hgrp_pkg and http_get_request_parser_core_assert.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries kind_i and data_byte_i.
//   kind_i = 1 clears the parser for a new connection; kind_i = 0 feeds one
//   request byte. Output channel (out_valid_o / out_stall_i) carries one
//   result when a request completes (status OK), a mismatch is seen
//   (malformed) or the byte count limit is hit (too long).
// Results are registered (output or skid register) at the accepting edge.
// Throughput: one byte per cycle while in_stall_o is low, set by the single
//   parser state register update per byte.
// Stall: results sit in an output register backed by a one-entry skid
//   register; in_stall_o rises only while the skid register is occupied, so
//   one more transaction is taken while a result waits.
// Reset: rst_ni (async, active low) empties both output registers and puts
//   the parser in the expect-method phase with all counts at zero.
// After an error, data bytes are dropped until a clear transaction.
`default_nettype none

module http_get_request_parser_core #(
  parameter int unsigned COUNT_BITS = hgrp_pkg::HGRP_COUNT_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  data_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [1:0]  status_o,
  output      logic [15:0] path_offset_o,
  output      logic [15:0] path_length_o,
  output      logic        http_minor_o,
  output      logic [15:0] request_length_o
);
  import hgrp_pkg::*;

  `include "http_get_request_parser_core_assert.svh"

  typedef struct packed {
    phase_e                phase;
    logic [2:0]            match_idx;
    logic [COUNT_BITS-1:0] byte_cnt;
    logic [COUNT_BITS-1:0] path_start;
    logic [COUNT_BITS-1:0] path_cnt;
    logic                  version;
    logic                  saw_cr;
    logic                  line_text;
    logic                  err_hold;
  } parse_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] path_offset;
    logic [15:0] path_length;
    logic        minor;
    logic [15:0] req_length;
  } result_t;

  localparam parse_t PARSE_RESET = '{
    phase:      PH_METHOD,
    match_idx:  3'd0,
    byte_cnt:   '0,
    path_start: '0,
    path_cnt:   '0,
    version:    1'b0,
    saw_cr:     1'b0,
    line_text:  1'b0,
    err_hold:   1'b0
  };

  parse_t  st_q, st_d;
  result_t res;
  logic    res_valid;
  logic    in_accept;

  result_t main_q, main_d, skid_q, skid_d;
  logic    main_valid_q, main_valid_d, skid_valid_q, skid_valid_d;
  logic    pop;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    st_d      = st_q;
    res       = '0;
    res_valid = 1'b0;
    if (kind_i) begin
      st_d = PARSE_RESET;
    end else if (st_q.err_hold) begin
      st_d = st_q;
    end else if (&st_q.byte_cnt) begin
      st_d.err_hold = 1'b1;
      res_valid     = 1'b1;
      res.status    = STATUS_TOO_LONG;
    end else begin
      st_d.byte_cnt = st_q.byte_cnt + COUNT_BITS'(1);
      case (st_q.phase)
        PH_METHOD: begin
          if (data_byte_i != method_char(st_q.match_idx[1:0])) begin
            st_d.err_hold = 1'b1;
            res_valid     = 1'b1;
            res.status    = STATUS_MALFORMED;
          end else if (st_q.match_idx[1:0] == 2'd3) begin
            st_d.match_idx = 3'd0;
            st_d.phase     = PH_SKIP1;
          end else begin
            st_d.match_idx = st_q.match_idx + 3'd1;
          end
        end
        PH_SKIP1: begin
          if (data_byte_i != CHAR_SPACE) begin
            st_d.path_start = st_q.byte_cnt;
            st_d.path_cnt   = COUNT_BITS'(1);
            st_d.phase      = PH_PATH;
          end
        end
        PH_PATH: begin
          if (data_byte_i == CHAR_SPACE) begin
            st_d.phase = PH_SKIP2;
          end else begin
            st_d.path_cnt = st_q.path_cnt + COUNT_BITS'(1);
          end
        end
        PH_SKIP2: begin
          if (data_byte_i != CHAR_SPACE) begin
            st_d.phase = PH_PROTO;
            if (data_byte_i != proto_char(3'd0)) begin
              st_d.match_idx = 3'd0;
              st_d.err_hold  = 1'b1;
              res_valid      = 1'b1;
              res.status     = STATUS_MALFORMED;
            end else begin
              st_d.match_idx = 3'd1;
            end
          end
        end
        PH_PROTO: begin
          if (st_q.match_idx == 3'd7 || data_byte_i != proto_char(st_q.match_idx)) begin
            st_d.err_hold = 1'b1;
            res_valid     = 1'b1;
            res.status    = STATUS_MALFORMED;
          end else if (st_q.match_idx == 3'd6) begin
            st_d.match_idx = 3'd0;
            st_d.phase     = PH_DIGIT;
          end else begin
            st_d.match_idx = st_q.match_idx + 3'd1;
          end
        end
        PH_DIGIT: begin
          if (data_byte_i != CHAR_ZERO && data_byte_i != CHAR_ONE) begin
            st_d.err_hold = 1'b1;
            res_valid     = 1'b1;
            res.status    = STATUS_MALFORMED;
          end else begin
            st_d.version   = data_byte_i[0];
            st_d.phase     = PH_HEADERS;
            st_d.line_text = 1'b1;
            st_d.saw_cr    = 1'b0;
          end
        end
        PH_HEADERS: begin
          if (st_q.saw_cr && data_byte_i == CHAR_LF) begin
            st_d.saw_cr = 1'b0;
            if (!st_q.line_text) begin
              res_valid       = 1'b1;
              res.status      = STATUS_OK;
              res.path_offset = 16'(32'(st_q.path_start));
              res.path_length = 16'(32'(st_q.path_cnt));
              res.minor       = st_q.version;
              res.req_length  = 16'(32'(st_d.byte_cnt));
              st_d            = PARSE_RESET;
              st_d.err_hold   = st_q.err_hold;
            end else begin
              st_d.line_text = 1'b0;
            end
          end else if (data_byte_i == CHAR_CR) begin
            st_d.saw_cr = 1'b1;
            if (st_q.saw_cr) begin
              st_d.line_text = 1'b1;
            end
          end else begin
            st_d.saw_cr    = 1'b0;
            st_d.line_text = 1'b1;
          end
        end
        default: begin
          st_d.err_hold = 1'b1;
          res_valid     = 1'b1;
          res.status    = STATUS_MALFORMED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PARSE_RESET;
    end else if (in_accept) begin
      st_q <= st_d;
    end
  end

  assign pop = main_valid_q && !out_stall_i;

  always_comb begin
    main_d       = main_q;
    skid_d       = skid_q;
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else if (in_accept && res_valid) begin
        main_d = res;
      end else begin
        main_valid_d = 1'b0;
      end
    end else if (in_accept && res_valid) begin
      if (main_valid_q) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end else begin
        main_d       = res;
        main_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = main_valid_q;
  assign status_o         = main_q.status;
  assign path_offset_o    = main_q.path_offset;
  assign path_length_o    = main_q.path_length;
  assign http_minor_o     = main_q.minor;
  assign request_length_o = main_q.req_length;

  `HGRP_ASSERT_NOW(a_skid_needs_main, clk_i, rst_ni, skid_valid_q, main_valid_q,
                   "skid register holds a result while the output register is empty")
  `HGRP_ASSERT_NXT(a_hold_freezes_count, clk_i, rst_ni,
                   in_accept && !kind_i && st_q.err_hold, $stable(st_q.byte_cnt),
                   "byte count moved while the error hold is set")
  `HGRP_ASSERT_NOW(a_phase_needs_bytes, clk_i, rst_ni, st_q.phase != PH_METHOD,
                   st_q.byte_cnt != '0,
                   "parser left the method phase without counting bytes")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for http_get_request_parser_core: byte stream in, one report per request.
// Predicts each report in the bench and checks it in order. Uses hgrp_pkg codes and constants.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hgrp_pkg::*;

  localparam int unsigned COUNT_LIMIT = (2 ** HGRP_COUNT_BITS) - 1;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned FED_TARGET  = 1350;
  localparam int unsigned CALM_TAIL   = 150;
  localparam logic [31:0] METHOD_TEXT = "GET ";
  localparam logic [55:0] PROTO_TEXT  = "HTTP/1.";

  typedef struct packed {
    status_e     status;
    logic [15:0] path_offset;
    logic [15:0] path_length;
    logic        http_minor;
    logic [15:0] request_length;
  } report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] path_offset_o;
  logic [15:0] path_length_o;
  logic        http_minor_o;
  logic [15:0] request_length_o;

  http_get_request_parser_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .path_offset_o    (path_offset_o),
    .path_length_o    (path_length_o),
    .http_minor_o     (http_minor_o),
    .request_length_o (request_length_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // parser state mirror
  phase_e      ps_phase;
  int unsigned ps_idx;
  int unsigned ps_count;
  int unsigned ps_path_start;
  int unsigned ps_path_len;
  logic        ps_minor;
  bit          ps_cr;
  bit          ps_text;
  bit          ps_hold;

  report_t     pending_reports[$];
  logic [7:0]  req_bytes[$];
  bit          idle_on = 1'b0;
  int unsigned items_fed = 0;
  int unsigned n_ok = 0;
  int unsigned n_malformed = 0;
  int unsigned n_too_long = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;

  function automatic void restart_parse();
    ps_phase      = PH_METHOD;
    ps_idx        = 0;
    ps_count      = 0;
    ps_path_start = 0;
    ps_path_len   = 0;
    ps_minor      = 1'b0;
    ps_cr         = 1'b0;
    ps_text       = 1'b0;
  endfunction

  function automatic bit parse_byte(input logic kind, input logic [7:0] b, output report_t rep);
    int unsigned pos;
    bit bad;
    bit done;
    rep.status         = STATUS_OK;
    rep.path_offset    = '0;
    rep.path_length    = '0;
    rep.http_minor     = 1'b0;
    rep.request_length = '0;
    bad  = 1'b0;
    done = 1'b0;
    if (kind) begin
      restart_parse();
      ps_hold = 1'b0;
      return 1'b0;
    end
    if (ps_hold) return 1'b0;
    if (ps_count >= COUNT_LIMIT) begin
      ps_hold    = 1'b1;
      rep.status = STATUS_TOO_LONG;
      return 1'b1;
    end
    pos = ps_count;
    ps_count++;
    case (ps_phase)
      PH_METHOD: begin
        if (b != METHOD_TEXT[8*(3-ps_idx) +: 8]) begin
          bad = 1'b1;
        end else begin
          ps_idx++;
          if (ps_idx == 4) begin
            ps_idx   = 0;
            ps_phase = PH_SKIP1;
          end
        end
      end
      PH_SKIP1: begin
        if (b != CHAR_SPACE) begin
          ps_path_start = pos;
          ps_path_len   = 1;
          ps_phase      = PH_PATH;
        end
      end
      PH_PATH: begin
        if (b == CHAR_SPACE) ps_phase = PH_SKIP2;
        else ps_path_len++;
      end
      PH_SKIP2: begin
        if (b != CHAR_SPACE) begin
          ps_phase = PH_PROTO;
          ps_idx   = 1;
          if (b != PROTO_TEXT[55:48]) bad = 1'b1;
        end
      end
      PH_PROTO: begin
        if (ps_idx >= 7 || b != PROTO_TEXT[8*(6-ps_idx) +: 8]) begin
          bad = 1'b1;
        end else begin
          ps_idx++;
          if (ps_idx == 7) begin
            ps_idx   = 0;
            ps_phase = PH_DIGIT;
          end
        end
      end
      PH_DIGIT: begin
        if (b != CHAR_ZERO && b != CHAR_ONE) begin
          bad = 1'b1;
        end else begin
          ps_minor = b[0];
          ps_phase = PH_HEADERS;
          ps_text  = 1'b1;
          ps_cr    = 1'b0;
        end
      end
      PH_HEADERS: begin
        if (ps_cr && b == CHAR_LF) begin
          ps_cr = 1'b0;
          if (!ps_text) done = 1'b1;
          else ps_text = 1'b0;
        end else begin
          if (ps_cr) ps_text = 1'b1;
          if (b == CHAR_CR) begin
            ps_cr = 1'b1;
          end else begin
            ps_cr   = 1'b0;
            ps_text = 1'b1;
          end
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      ps_hold    = 1'b1;
      rep.status = STATUS_MALFORMED;
      return 1'b1;
    end
    if (done) begin
      rep.path_offset    = ps_path_start[15:0];
      rep.path_length    = ps_path_len[15:0];
      rep.http_minor     = ps_minor;
      rep.request_length = ps_count[15:0];
      restart_parse();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] rand_byte_except(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == avoid);
    return b;
  endfunction

  // driver side: called at a falling edge, returns at a falling edge
  task automatic send_item(input logic kind, input logic [7:0] b);
    report_t rep;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_fed++;
    if (parse_byte(kind, b, rep)) begin
      pending_reports.push_back(rep);
    end
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic send_clear();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_basic_requests();
    idle_on = 1'b1;
    send_text("GET / HTTP/1.0\015\012\015\012");
    send_text("GET    /index.html  HTTP/1.1\015\012Host: x\015\012\015\012");
  endtask

  // path starting with CR, lone LF, CR CR LF, CR before text, 0x00 and 0xFF bytes
  task automatic test_odd_lines();
    send_text("GET ");
    send_item(1'b0, CHAR_CR);
    send_item(1'b0, 8'hFF);
    send_text(" HTTP/1.1");
    send_item(1'b0, 8'h00);
    send_text("\012\015\015\012\015X\015\012");
    send_item(1'b0, 8'hFF);
    send_text("\015\012\015\012");
  endtask

  task automatic test_malformed();
    string bad_lines[$];
    bad_lines = '{"X", "GEX", "GET /a XTTP", "GET /a HTTZ", "GET /a HTTP/2",
                  "GET /a HTTP/1.2", "GET / HTTP/1.0\015\012\015\012GETX"};
    foreach (bad_lines[i]) begin
      send_text(bad_lines[i]);
      send_text("GET / HTTP/1.1\015\012\015\012");
      send_clear();
    end
  endtask

  task automatic test_clear_midway();
    send_item(1'b1, 8'hFF);
    send_text("GET /partial HTT");
    send_clear();
    send_text("GET /p HTTP/1.0\015\012a\015\012\015\012");
  endtask

  task automatic test_drain_pause();
    send_text("GET /q HTTP/1.1\015\012\015\012");
    wait_drained();
    send_text("GET /r HTTX");
    wait_drained();
    send_clear();
    send_text("GET /s HTTP/1.0\015\012\015\012");
  endtask

  task automatic make_request();
    int unsigned n;
    req_bytes.delete();
    for (int i = 3; i >= 0; i--) req_bytes.push_back(METHOD_TEXT[8*i +: 8]);
    repeat ($urandom_range(0, 3)) req_bytes.push_back(CHAR_SPACE);
    repeat ($urandom_range(1, 8)) req_bytes.push_back(rand_byte_except(CHAR_SPACE));
    repeat ($urandom_range(1, 3)) req_bytes.push_back(CHAR_SPACE);
    for (int i = 6; i >= 0; i--) req_bytes.push_back(PROTO_TEXT[8*i +: 8]);
    req_bytes.push_back($urandom_range(0, 1) ? CHAR_ONE : CHAR_ZERO);
    repeat ($urandom_range(0, 3)) req_bytes.push_back(rand_byte_except(CHAR_CR));
    req_bytes.push_back(CHAR_CR);
    req_bytes.push_back(CHAR_LF);
    repeat ($urandom_range(0, 2)) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 15) == 0) req_bytes.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        else req_bytes.push_back(rand_byte_except(CHAR_CR));
      end
      req_bytes.push_back(CHAR_CR);
      req_bytes.push_back(CHAR_LF);
    end
    req_bytes.push_back(CHAR_CR);
    req_bytes.push_back(CHAR_LF);
  endtask

  task automatic test_random_traffic();
    int unsigned choice;
    int unsigned cut;
    while (items_fed < FED_TARGET) begin
      idle_on = (items_fed < FED_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      make_request();
      choice = $urandom_range(0, 15);
      cut    = req_bytes.size();
      case (choice)
        0: repeat ($urandom_range(1, 5)) req_bytes.push_front(8'($urandom_range(0, 255)));
        1: req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        2: cut = $urandom_range(1, req_bytes.size() - 1);
        default: ;
      endcase
      for (int i = 0; i < cut; i++) send_item(1'b0, req_bytes[i]);
      if (choice == 2) send_clear();
      if (ps_hold) begin
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(1, 6)) send_item(1'b0, 8'($urandom_range(0, 255)));
        end
        send_clear();
      end
    end
    idle_on = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (stall_left != 0) stall_left--;
    else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
    out_stall_i <= idle_on && (stall_left != 0);
  end

  always @(posedge clk_i) begin
    report_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: status %0d", status_o);
        fail_count++;
      end else begin
        exp = pending_reports.pop_front();
        case (exp.status)
          STATUS_OK:        n_ok++;
          STATUS_MALFORMED: n_malformed++;
          default:          n_too_long++;
        endcase
        if (status_o !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, status_o);
          fail_count++;
        end
        if (path_offset_o !== exp.path_offset) begin
          $error("path_offset: expected %0d, got %0d", exp.path_offset, path_offset_o);
          fail_count++;
        end
        if (path_length_o !== exp.path_length) begin
          $error("path_length: expected %0d, got %0d", exp.path_length, path_length_o);
          fail_count++;
        end
        if (http_minor_o !== exp.http_minor) begin
          $error("http_minor: expected %0d, got %0d", exp.http_minor, http_minor_o);
          fail_count++;
        end
        if (request_length_o !== exp.request_length) begin
          $error("request_length: expected %0d, got %0d", exp.request_length,
                 request_length_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("[http_get_request_parser_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    restart_parse();
    ps_hold = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_basic_requests();
    test_odd_lines();
    test_malformed();
    test_clear_midway();
    test_drain_pause();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("covered: directed edge cases, malformed and cleared requests, random traffic");
    $display("reports checked: %0d complete, %0d malformed, %0d too long",
             n_ok, n_malformed, n_too_long);
    if (fail_count == 0) begin
      $display("[http_get_request_parser_core] OK");
    end else begin
      $display("[http_get_request_parser_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/hgrp_pkg.sv
hdl/http_get_request_parser_core.sv
tb/testbench.sv
